[rtl/core/itll_pkg.sv]
`default_nettype none

package itll_pkg;

  // Table geometry
  localparam int TABLE_DEPTH   = 1024;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);

  // Field widths fixed by the interface
  localparam int ENTRY_INDEX_W = 10;
  localparam int Q_W           = 32;
  localparam int WEIGHT_W      = 24;
  localparam int LEN_W         = 11;
  localparam int SUM_W         = 64;
  localparam int COUNT_W       = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLUX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_INCLUSIVE = 2'd3;

  localparam logic signed [Q_W-1:0] MIN_FLUX_RST     = 32'sd0;
  localparam logic [Q_W-1:0]        INV_STEP_RST     = 32'd65536;
  localparam logic [LEN_W-1:0]      TABLE_LENGTH_RST = 11'd1024;
  localparam logic                  EDGE_INCL_RST    = 1'b0;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ACCUM = 1'b1;

  // round(ln 2 * 2^32)
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

endpackage

`default_nettype wire

[rtl/core/itll_ifs.sv]
`default_nettype none

interface itll_item_if;
  import itll_pkg::*;

  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [ENTRY_INDEX_W-1:0]         entry_index;
  logic signed [Q_W-1:0]            entry_value;
  logic signed [Q_W-1:0]            flux;
  logic [WEIGHT_W-1:0]              weight;
  logic                             last;

  modport source (
    output valid, command, entry_index, entry_value, flux, weight, last,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, entry_value, flux, weight, last,
    output ready
  );
endinterface

interface itll_result_if;
  import itll_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [SUM_W-1:0] log_likelihood;
  logic [COUNT_W-1:0]    samples_used;
  logic                  overflowed;

  modport source (
    output valid, log_likelihood, samples_used, overflowed,
    input  ready
  );

  modport sink (
    input  valid, log_likelihood, samples_used, overflowed,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/itll_ram.sv]
`default_nettype none

module itll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/interpolated_table_log_likelihood.sv]
`default_nettype none

// Interpolated table log-likelihood accumulator.
//
// items   : input channel (valid/ready). A load transaction (command = 0) writes
//           entry_value into the table at entry_index; items.ready stays high.
//           An accumulate transaction (command = 1) looks flux up in the table,
//           interpolates linearly between neighbouring entries and adds
//           weight * value into a saturating Q48.16 sum.
// results : output channel (valid/ready). One transaction per accumulate with
//           last = 1: the sum times ln 2 as signed Q32.32, the count of samples
//           with nonzero weight, and an overflow flag. The run then clears.
// cfg_*   : write port for the four settings; write only while the block idles.
// Sequence: an accumulate holds items.ready low while it steps through the
//           offset x reciprocal, slope x fraction and weight x value multiplies
//           and the registered table read, so no new item is taken meanwhile.
//           With last set the four-step ln 2 scaling follows: the result is
//           presented from the output register and items.ready returns with it.
// Stall   : a result waits in the output register; a second result holds the
//           block in its last step until the receiver drains the first one.
// Reset   : rst is synchronous; it clears the sum, count, overflow flag, output
//           valid, resets the configuration. Table contents are undefined until loaded.
module interpolated_table_log_likelihood (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [itll_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [itll_pkg::CFG_DATA_W-1:0]    cfg_data,
  itll_item_if.sink                               items,
  itll_result_if.source                           results
);

  import itll_pkg::*;

  // Sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_ADDR   = 4'd2;
  localparam logic [3:0] S_INTERP = 4'd3;
  localparam logic [3:0] S_VALUE  = 4'd4;
  localparam logic [3:0] S_TERM   = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_ABS    = 4'd7;
  localparam logic [3:0] S_LNMUL  = 4'd8;
  localparam logic [3:0] S_COMB   = 4'd9;
  localparam logic [3:0] S_LIM    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // Configuration registers
  logic signed [Q_W-1:0] min_flux;
  logic [Q_W-1:0]        inv_step;
  logic [LEN_W-1:0]      table_length;
  logic                  edge_inclusive;

  // Control state
  logic [3:0]              state;
  logic [3:0]              state_next;
  logic signed [SUM_W-1:0] sum;
  logic [COUNT_W-1:0]      count;
  logic                    ovf;
  logic                    out_valid;

  // Per-item datapath registers
  logic signed [Q_W:0]       flux_off;
  logic [WEIGHT_W-1:0]       weight_q;
  logic                      last_q;
  logic [2*Q_W-1:0]          delt;
  logic                      off_neg;
  logic                      off_zero;
  logic [Q_W-2:0]            frac;
  logic signed [SUM_W-1:0]   slope_prod;
  logic signed [Q_W-1:0]     p0_q;
  logic signed [Q_W-1:0]     value;
  logic signed [Q_W+WEIGHT_W:0] term;

  // Output scaling registers
  logic                 neg;
  logic [SUM_W-1:0]     mag;
  logic [SUM_W-1:0]     prod_hi;
  logic [SUM_W-1:0]     prod_lo;
  logic                 sat_hi;
  logic [SUM_W-1:0]     scaled;
  logic                 sat;

  // Output register
  logic signed [SUM_W-1:0] out_ll;
  logic [COUNT_W-1:0]      out_count;
  logic                    out_ovf;

  // Memory ports
  logic                  load_we;
  logic [IDX_W-1:0]      load_addr;
  logic [IDX_W-1:0]      rd_addr0;
  logic [IDX_W-1:0]      rd_addr1;
  logic [Q_W-1:0]        rd_data0;
  logic [Q_W-1:0]        rd_data1;

  // Combinational helpers
  logic                      in_accept;
  logic                      out_free;
  logic [LEN_W-1:0]          n_eff;
  logic [LEN_W-1:0]          n_m1;
  logic [LEN_W-1:0]          n_m2;
  logic [Q_W-1:0]            delt_hi;
  logic                      below;
  logic                      above;
  logic [Q_W-2:0]            frac_next;
  logic signed [Q_W:0]       slope;
  logic signed [SUM_W:0]     slope_full;
  logic signed [SUM_W:0]     interp_acc;
  logic signed [Q_W+WEIGHT_W:0] term_full;
  logic signed [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]          limit;

  assign in_accept   = items.valid && items.ready;
  assign out_free    = !out_valid || results.ready;
  assign items.ready = (state == S_IDLE);

  assign results.valid          = out_valid;
  assign results.log_likelihood = out_ll;
  assign results.samples_used   = out_count;
  assign results.overflowed     = out_ovf;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_flux       <= MIN_FLUX_RST;
      inv_step       <= INV_STEP_RST;
      table_length   <= TABLE_LENGTH_RST;
      edge_inclusive <= EDGE_INCL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_FLUX:       min_flux       <= signed'(cfg_data[Q_W-1:0]);
        CFG_INV_STEP:       inv_step       <= cfg_data[Q_W-1:0];
        CFG_TABLE_LENGTH:   table_length   <= cfg_data[LEN_W-1:0];
        CFG_EDGE_INCLUSIVE: edge_inclusive <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the table length to the usable range
  always_comb begin
    if (table_length < LEN_W'(2)) begin
      n_eff = LEN_W'(2);
    end else if (32'(table_length) > TABLE_DEPTH) begin
      n_eff = LEN_W'(TABLE_DEPTH);
    end else begin
      n_eff = table_length;
    end
    n_m1 = n_eff - LEN_W'(1);
    n_m2 = n_eff - LEN_W'(2);
  end

  // Table loads go to both copies so each can serve one read address
  assign load_we   = in_accept && (items.command == CMD_LOAD)
                     && (32'(items.entry_index) < TABLE_DEPTH);
  assign load_addr = IDX_W'(items.entry_index);

  // Edge decisions and read addresses, used in S_ADDR
  assign delt_hi = delt[2*Q_W-1:Q_W];

  always_comb begin
    below = off_neg || (edge_inclusive && off_zero);
    if (edge_inclusive) begin
      above = (delt_hi >= 32'(n_m2));
    end else begin
      above = (delt_hi > 32'(n_m2))
              || ((delt_hi == 32'(n_m2)) && (delt[Q_W-1:0] != '0));
    end
    if (below) begin
      rd_addr0  = '0;
      frac_next = '0;
    end else if (above) begin
      rd_addr0  = IDX_W'(n_m1);
      frac_next = '0;
    end else begin
      rd_addr0  = delt_hi[IDX_W-1:0];
      frac_next = delt[Q_W-1:1];
    end
    // On an edge both ports read the same entry, so the slope is exactly zero
    rd_addr1 = (below || above) ? rd_addr0 : (rd_addr0 + IDX_W'(1));
  end

  itll_ram #(
    .WIDTH (Q_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table_lo (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (items.entry_value),
    .raddr (rd_addr0),
    .rdata (rd_data0)
  );

  itll_ram #(
    .WIDTH (Q_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table_hi (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (items.entry_value),
    .raddr (rd_addr1),
    .rdata (rd_data1)
  );

  // Arithmetic between stages
  always_comb begin
    slope      = {rd_data1[Q_W-1], rd_data1} - {rd_data0[Q_W-1], rd_data0};
    slope_full = slope * $signed({1'b0, frac});
    interp_acc = ({{(SUM_W-Q_W+1){p0_q[Q_W-1]}}, p0_q} <<< (Q_W-1))
                 + {slope_prod[SUM_W-1], slope_prod};
    term_full  = $signed({1'b0, weight_q}) * value;
    sum_ext    = {sum[SUM_W-1], sum}
                 + {{(SUM_W-Q_W-WEIGHT_W){term[Q_W+WEIGHT_W]}}, term};
    limit      = neg ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && (items.command == CMD_ACCUM)) begin
          state_next = S_MUL;
        end
      end
      S_MUL:    state_next = S_ADDR;
      S_ADDR:   state_next = S_INTERP;
      S_INTERP: state_next = S_VALUE;
      S_VALUE:  state_next = S_TERM;
      S_TERM:   state_next = S_ACC;
      S_ACC:    state_next = last_q ? S_ABS : S_IDLE;
      S_ABS:    state_next = S_LNMUL;
      S_LNMUL:  state_next = S_COMB;
      S_COMB:   state_next = S_LIM;
      S_LIM:    state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control registers: sequencer, run totals, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      // A zero-weight sample adds nothing and is not counted
      if ((state == S_ACC) && (weight_q != '0)) begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          // Saturate towards the sign of the true sum
          sum <= sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                : {1'b0, {(SUM_W-1){1'b1}}};
          ovf <= 1'b1;
        end else begin
          sum <= sum_ext[SUM_W-1:0];
        end
        if (count != '1) begin
          count <= count + COUNT_W'(1);
        end
      end
      if ((state == S_OUT) && out_free) begin
        sum       <= '0;
        count     <= '0;
        ovf       <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      flux_off <= {items.flux[Q_W-1], items.flux} - {min_flux[Q_W-1], min_flux};
      weight_q <= items.weight;
      last_q   <= items.last;
    end
    case (state)
      S_MUL: begin
        delt     <= flux_off[Q_W-1:0] * inv_step;
        off_neg  <= flux_off[Q_W];
        off_zero <= (flux_off == '0);
      end
      S_ADDR: begin
        frac <= frac_next;
      end
      S_INTERP: begin
        slope_prod <= slope_full[SUM_W-1:0];
        p0_q       <= signed'(rd_data0);
      end
      S_VALUE: begin
        value <= interp_acc[2*Q_W-2:Q_W-1];
      end
      S_TERM: begin
        term <= term_full;
      end
      S_ABS: begin
        neg <= sum[SUM_W-1];
        mag <= sum[SUM_W-1] ? (SUM_W'(0) - unsigned'(sum)) : unsigned'(sum);
      end
      S_LNMUL: begin
        prod_hi <= mag[SUM_W-1:Q_W] * LN2_Q32;
        prod_lo <= mag[Q_W-1:0] * LN2_Q32;
      end
      S_COMB: begin
        sat_hi <= |prod_hi[SUM_W-1:47];
        scaled <= {prod_hi[47:0], 16'b0} + {16'b0, prod_lo[SUM_W-1:16]};
      end
      S_LIM: begin
        if (sat_hi || (scaled > limit)) begin
          scaled <= limit;
          sat    <= 1'b1;
        end else begin
          sat    <= 1'b0;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_ll    <= neg ? signed'(SUM_W'(0) - scaled) : signed'(scaled);
          out_count <= count;
          out_ovf   <= ovf || sat;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/itll_checker.sv]
`default_nettype none

module itll_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 in_command,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [itll_pkg::SUM_W-1:0]    out_log_likelihood,
  input wire logic [itll_pkg::COUNT_W-1:0]         out_samples_used,
  input wire logic                                 out_overflowed
);

  import itll_pkg::*;

  // A load does not hold the block busy: it is ready again straight away
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_command == CMD_LOAD)) |=> in_ready)
    else $error("itll: not ready after a load transaction");

  // An accumulate holds the input side busy
  a_accum_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_command == CMD_ACCUM)) |=> !in_ready)
    else $error("itll: ready straight after an accumulate transaction");

  // A new result only appears out of the final step of a run
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("itll: result appeared while the block was idle");

  // A run with no counted samples sums to zero without overflow
  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_samples_used == '0)) |-> ((out_log_likelihood == '0) && !out_overflowed))
    else $error("itll: empty run gave a nonzero result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_log_likelihood)))
    else $error("itll: stalled result dropped or changed");

endmodule

bind interpolated_table_log_likelihood itll_checker u_itll_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (items.valid),
  .in_ready           (items.ready),
  .in_command         (items.command),
  .out_valid          (results.valid),
  .out_ready          (results.ready),
  .out_log_likelihood (results.log_likelihood),
  .out_samples_used   (results.samples_used),
  .out_overflowed     (results.overflowed)
);

`default_nettype wire
